[rtl/core/hk_pkg.sv]
`default_nettype none

package hk_pkg;

  // Sketch geometry. The row and column fields cover the table exactly,
  // so a bucket address is the row and column placed side by side.
  localparam int ROWS   = 4;
  localparam int COLS   = 1024;
  localparam int ROW_W  = 2;
  localparam int COL_W  = 10;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = ROWS * COLS;

  localparam int KEY_W  = 32;
  localparam int CNT_W  = 32;
  localparam int DRAW_W = 17;
  localparam int BKT_W  = KEY_W + CNT_W;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Above this count the threshold is flat at one.
  localparam logic [CNT_W-1:0] BAND_LIMIT = 32'd100;

  localparam int BANDS   = 10;
  localparam int BASE_W  = 17;
  localparam int SLOPE_W = 13;

  localparam logic [BASE_W-1:0] BAND_BASE [BANDS] = '{
    17'd96336, 17'd69284, 17'd43533, 17'd25472, 17'd14261,
    17'd7748,  17'd4119,  17'd2154,  17'd1112,  17'd568
  };
  localparam logic [SLOPE_W-1:0] BAND_SLOPE [BANDS] = '{
    13'd5312, 13'd2463, 13'd1142, 13'd529, 13'd245,
    13'd114,  13'd53,   13'd24,   13'd11,  13'd5
  };

  typedef enum logic [1:0] {
    OUT_INCR    = 2'd0,
    OUT_CLAIM   = 2'd1,
    OUT_REPLACE = 2'd2,
    OUT_KEEP    = 2'd3
  } hk_outcome_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [KEY_W-1:0]  fingerprint;
    logic [DRAW_W-1:0] random_draw;
  } hk_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_after;
    logic [CNT_W-1:0] count_after;
    hk_outcome_t      outcome;
  } hk_rsp_t;

  // Replacement threshold of an occupied bucket; a draw passes when it is
  // strictly below the returned value. The count is at least one here.
  function automatic logic [DRAW_W-1:0] hk_threshold(input logic [CNT_W-1:0] count);
    logic [6:0]              c7;
    logic [3:0]              band;
    logic [BASE_W+2:0]       prod;
    logic [DRAW_W-1:0]       thr;
    c7 = count[6:0];
    if (c7 <= 7'd10) begin
      band = 4'd0;
    end else if (c7 <= 7'd20) begin
      band = 4'd1;
    end else if (c7 <= 7'd30) begin
      band = 4'd2;
    end else if (c7 <= 7'd40) begin
      band = 4'd3;
    end else if (c7 <= 7'd50) begin
      band = 4'd4;
    end else if (c7 <= 7'd60) begin
      band = 4'd5;
    end else if (c7 <= 7'd70) begin
      band = 4'd6;
    end else if (c7 <= 7'd80) begin
      band = 4'd7;
    end else if (c7 <= 7'd90) begin
      band = 4'd8;
    end else begin
      band = 4'd9;
    end
    prod = 20'(BAND_SLOPE[band]) * 20'(c7);
    thr  = 17'(20'(BAND_BASE[band]) - prod);
    if (count > BAND_LIMIT) begin
      thr = 17'd1;
    end
    return thr;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hk_ram.sv]
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module hk_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/heavy_keeper_bucket_update_unit.sv]
`default_nettype none

// HeavyKeeper bucket update unit. A command beat (start high while busy is
// low) names one bucket by row and column and brings a fingerprint and a
// random draw; exactly one response beat follows, shown on rsp for a single
// cycle with done high, registered as the update state ends. The receiver
// cannot stall, so the response must be captured when done is seen. Each
// command passes through the synchronous read of the bucket memory, launched
// as the command is taken, and then the update state, in which the bucket is
// updated, written back and the response registered. busy is high in the
// update state, so a new command may be issued in the same cycle as the
// previous response appears. After reset the bucket memory is swept to zero,
// one bucket per cycle, all 4096 of them; busy is high for the whole sweep.
module heavy_keeper_bucket_update_unit
  import hk_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  hk_cmd_t cmd,
  output logic    busy,
  output logic    done,
  output hk_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state;

  logic [ADDR_W-1:0] clr_addr;
  hk_cmd_t           cmd_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BKT_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BKT_W-1:0]  ram_rdata;

  logic [KEY_W-1:0]  stored_key;
  logic [CNT_W-1:0]  stored_count;
  logic [KEY_W-1:0]  key_next;
  logic [CNT_W-1:0]  count_next;
  hk_outcome_t       outcome_next;

  hk_ram #(
    .WIDTH(BKT_W),
    .DEPTH(DEPTH)
  ) u_bucket_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // The read is launched straight from the command port; its data shows up
  // in the update cycle. Each update finishes its write before the next
  // command can be read, so no forwarding is needed.
  assign ram_raddr = {cmd.row, cmd.column};

  assign stored_key   = ram_rdata[BKT_W-1:CNT_W];
  assign stored_count = ram_rdata[CNT_W-1:0];

  // Update rule. A matching fingerprint always wins, even on an empty bucket.
  // An empty bucket is then claimed outright, and an occupied one is taken
  // over only when the draw falls below the count's threshold.
  always_comb begin
    key_next     = stored_key;
    count_next   = stored_count;
    outcome_next = OUT_KEEP;
    if (stored_key == cmd_q.fingerprint) begin
      if (stored_count != CNT_MAX) begin
        count_next = stored_count + 1'b1;
      end
      outcome_next = OUT_INCR;
    end else if (stored_count == '0) begin
      key_next     = cmd_q.fingerprint;
      count_next   = 32'd1;
      outcome_next = OUT_CLAIM;
    end else if (cmd_q.random_draw < hk_threshold(stored_count)) begin
      key_next     = cmd_q.fingerprint;
      count_next   = 32'd1;
      outcome_next = OUT_REPLACE;
    end
  end

  always_comb begin
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = {cmd_q.row, cmd_q.column};
        ram_wdata = {key_next, count_next};
      end
      default: begin
        ram_we    = 1'b0;
        ram_waddr = {cmd_q.row, cmd_q.column};
        ram_wdata = {key_next, count_next};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          done            <= 1'b1;
          rsp.key_after   <= key_next;
          rsp.count_after <= count_next;
          rsp.outcome     <= outcome_next;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A response beat only ever follows an update cycle.
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPDATE))
    else $error("response beat without an update cycle");

  // An accepted command holds the unit busy for its update cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && state == S_UPDATE))
    else $error("command accepted but no update followed");

  // A claimed or replaced bucket restarts at a count of one.
  a_takeover_count: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.outcome == OUT_CLAIM || rsp.outcome == OUT_REPLACE))
      |-> (rsp.count_after == 32'd1))
    else $error("taken-over bucket does not hold a count of one");

  // After any update the bucket is occupied.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.count_after != '0))
    else $error("bucket count is zero after an update");

endmodule

`default_nettype wire
